>>> sv/sep_pkg.sv
// shared constants, types and register codes for the sobel edge stream unit
package sep_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 24;
    localparam int LINE_W        = 2 * PIX_W;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int CH_W          = 8;
    localparam int GRAD_W        = 11;
    localparam int SUM_W         = 2 * GRAD_W;
    localparam int SAT_SUM       = 64770;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SQR,
        ST_MSTART,
        ST_MAG,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } mag_ctl_t;

endpackage

>>> sv/sep_ram.sv
// generic single-port-write, registered-read memory
module sep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sep_mag.sv
// iterative rounded square root with clamp, one result bit per cycle
module sep_mag (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sep_pkg::SUM_W-1:0]      sum,
    output logic                           busy,
    output logic [sep_pkg::CH_W-1:0]       result
);

    logic [16:0]                s_reg;
    logic                       sat_reg;
    logic [sep_pkg::CH_W-1:0]   n_reg;
    logic [sep_pkg::CH_W-1:0]   n_next;
    logic [2:0]                 bit_reg;
    logic                       busy_reg;
    logic [sep_pkg::CH_W-1:0]   trial;
    logic [15:0]                prod;

    always_comb
    begin
        trial  = n_reg | (8'd1 << bit_reg);
        prod   = 16'(trial) * 16'(trial - 8'd1);
        n_next = ({1'b0, prod} < s_reg) ? trial : n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            bit_reg  <= 3'd7;
        end
        else if (busy_reg)
        begin
            bit_reg <= bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg   <= sum[16:0];
            sat_reg <= (sum > sep_pkg::SUM_W'(sep_pkg::SAT_SUM));
            n_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= n_next;
        end
    end

    assign busy   = busy_reg;
    assign result = sat_reg ? 8'hFF : n_reg;

endmodule

>>> sv/sobel_edge_rgb_stream_unit.sv
// top level: line store, 3x3 window, sobel gradients and magnitude per channel
//
// Usage: pixels enter in raster order on the input channel (in_valid /
// in_stall), each frame followed by frame_width+1 transfers with flush set.
// An input transfer at linear slot t >= frame_width+1 yields one result for
// the pixel frame_width+1 slots back; earlier slots yield nothing. Results
// leave on the output channel (out_valid / out_stall); last_pixel marks the
// final pixel of a frame.
// Timing: one item at a time. A slot with no result passes through the
// transfer with line store read, then the update. A slot with a result passes
// through transfer, update, gradient sum, squares, root start, the bit-serial
// square root units, then the output register load. The single read port of
// the line store and the serial root set this sequence.
// Registers on the cfg channel (index 0 frame_width, 1 frame_height) are
// written only while idle; a write to either register restarts the frame.
// Reset: width 1024, height 1, window and counters clear. The line store is
// not cleared; its unwritten entries only reach masked window taps.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits only when its own result is ready to go out.
module sobel_edge_rgb_stream_unit #(
    parameter int MAX_WIDTH = sep_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         red_in,
    input  logic [7:0]                         green_in,
    input  logic [7:0]                         blue_in,
    input  logic                               flush,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         red_edge,
    output logic [7:0]                         green_edge,
    output logic [7:0]                         blue_edge,
    output logic                               last_pixel,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sep_pkg::FH_W-1:0]           cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = sep_pkg::FH_W + 1;
    localparam int PW = sep_pkg::PIX_W;
    localparam int LW = sep_pkg::LINE_W;
    localparam int GW = sep_pkg::GRAD_W;
    localparam int SW = sep_pkg::SUM_W;

    sep_pkg::state_t state_reg, state_next;

    logic [sep_pkg::FW_W-1:0]   fw_reg;
    logic [sep_pkg::FH_W-1:0]   fh_reg;
    logic [CW-1:0]              col_reg;
    logic [sep_pkg::FH_W-1:0]   row_reg;
    logic [CW-1:0]              flush_cnt_reg;
    logic [PW-1:0]              win_reg [9];
    logic [PW-1:0]              pix_reg;
    logic [8:0]                 tap_ok_reg;
    logic                       last_reg;
    logic signed [GW-1:0]       gx_reg [3];
    logic signed [GW-1:0]       gy_reg [3];
    logic [SW-1:0]              sq_reg [3];
    logic                       out_valid_reg;
    logic [7:0]                 red_reg, green_reg, blue_reg;
    logic                       last_out_reg;

    logic [CW-1:0]              w_eff;
    logic [sep_pkg::FH_W-1:0]   h_eff;
    logic [31:0]                fw32;
    logic                       post;
    logic [RW-1:0]              r_cur;
    logic [CW-1:0]              c_cur;
    logic                       emit;
    logic [RW-1:0]              cr;
    logic [CW-1:0]              cc;
    logic [8:0]                 tap_ok;
    logic                       in_xfer;
    logic                       cfg_xfer;
    logic                       out_load;
    logic [LW-1:0]              ls_rdata;
    logic [PW-1:0]              one_back, two_back;
    logic signed [GW-1:0]       gx_c [3];
    logic signed [GW-1:0]       gy_c [3];
    sep_pkg::mag_ctl_t          mag_ctl [3];
    logic [7:0]                 mag_res [3];
    logic                       mag_start;

    assign in_xfer  = in_valid && !in_stall;
    assign cfg_xfer = cfg_valid && cfg_ready;

    // effective frame size
    always_comb
    begin
        fw32 = 32'(fw_reg);
        if (fw32 == 32'd0)
        begin
            fw32 = 32'd1;
        end
        else if (fw32 > 32'(MAX_WIDTH))
        begin
            fw32 = 32'(MAX_WIDTH);
        end
        w_eff = CW'(fw32);
        h_eff = (fh_reg == '0) ? sep_pkg::FH_W'(1) : fh_reg;
    end

    // slot position, taps and result flags
    always_comb
    begin
        post = (row_reg >= h_eff);
        if (!post)
        begin
            r_cur = RW'(row_reg);
            c_cur = col_reg;
        end
        else if (flush_cnt_reg < w_eff)
        begin
            r_cur = RW'(h_eff);
            c_cur = flush_cnt_reg;
        end
        else
        begin
            r_cur = RW'(h_eff) + RW'(1);
            c_cur = '0;
        end
        emit = (r_cur >= RW'(2)) || ((r_cur == RW'(1)) && (c_cur != '0));
        if (c_cur != '0)
        begin
            cr = r_cur - RW'(1);
            cc = c_cur - CW'(1);
        end
        else
        begin
            cr = r_cur - RW'(2);
            cc = w_eff - CW'(1);
        end
        for (int k = 0; k < 9; k++)
        begin
            tap_ok[k] = 1'b1;
            if (k / 3 == 0 && cr == '0)
            begin
                tap_ok[k] = 1'b0;
            end
            if (k / 3 == 2 && (cr + RW'(1)) >= RW'(h_eff))
            begin
                tap_ok[k] = 1'b0;
            end
            if (k % 3 == 0 && cc == '0)
            begin
                tap_ok[k] = 1'b0;
            end
            if (k % 3 == 2 && ({1'b0, cc} + (CW + 1)'(1)) >= {1'b0, w_eff})
            begin
                tap_ok[k] = 1'b0;
            end
        end
    end

    sep_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (state_reg == sep_pkg::ST_READ),
        .waddr (c_cur[AW-1:0]),
        .wdata ({one_back, pix_reg}),
        .re    (in_xfer),
        .raddr (c_cur[AW-1:0]),
        .rdata (ls_rdata)
    );

    assign one_back = ls_rdata[PW-1:0];
    assign two_back = ls_rdata[LW-1:PW];

    // frame size registers, counters, window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= sep_pkg::FW_W'(1024);
            fh_reg        <= sep_pkg::FH_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            flush_cnt_reg <= '0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                sep_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data[sep_pkg::FW_W-1:0];
                sep_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
            if (cfg_index == sep_pkg::REG_FRAME_WIDTH ||
                cfg_index == sep_pkg::REG_FRAME_HEIGHT)
            begin
                col_reg       <= '0;
                row_reg       <= '0;
                flush_cnt_reg <= '0;
                for (int k = 0; k < 9; k++)
                begin
                    win_reg[k] <= '0;
                end
            end
        end
        else if (state_reg == sep_pkg::ST_READ)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= two_back;
            win_reg[5] <= one_back;
            win_reg[8] <= pix_reg;
            if (!post)
            begin
                if ((col_reg + CW'(1)) >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + sep_pkg::FH_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else if (flush_cnt_reg < w_eff)
            begin
                flush_cnt_reg <= flush_cnt_reg + CW'(1);
            end
            else
            begin
                col_reg       <= '0;
                row_reg       <= '0;
                flush_cnt_reg <= '0;
            end
        end
    end

    // gradients from the shifted window
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [9:0] v [9];
            for (int k = 0; k < 9; k++)
            begin
                v[k] = tap_ok_reg[k] ? 10'(win_reg[k][(16 - 8*ch) +: 8]) : 10'd0;
            end
            gx_c[ch] = GW'(v[2] + (v[5] << 1) + v[8]) - GW'(v[0] + (v[3] << 1) + v[6]);
            gy_c[ch] = GW'(v[6] + (v[7] << 1) + v[8]) - GW'(v[0] + (v[1] << 1) + v[2]);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg <= (!post && !flush) ? {red_in, green_in, blue_in} : '0;
        end
        if (state_reg == sep_pkg::ST_READ)
        begin
            tap_ok_reg <= tap_ok;
            last_reg   <= ((cr + RW'(1)) == RW'(h_eff)) && ((cc + CW'(1)) == w_eff);
        end
        if (state_reg == sep_pkg::ST_SUM)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                gx_reg[ch] <= gx_c[ch];
                gy_reg[ch] <= gy_c[ch];
            end
        end
        if (state_reg == sep_pkg::ST_SQR)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                sq_reg[ch] <= SW'(gx_reg[ch] * gx_reg[ch]) + SW'(gy_reg[ch] * gy_reg[ch]);
            end
        end
        if (out_load)
        begin
            red_reg      <= mag_res[0];
            green_reg    <= mag_res[1];
            blue_reg     <= mag_res[2];
            last_out_reg <= last_reg;
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_mag
        assign mag_ctl[ch].start = mag_start;
        sep_mag u_mag (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (mag_ctl[ch].start),
            .sum    (sq_reg[ch]),
            .busy   (mag_ctl[ch].busy),
            .result (mag_res[ch])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sep_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cfg_ready  = 1'b0;
        mag_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            sep_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = sep_pkg::ST_READ;
                end
            end
            sep_pkg::ST_READ:
            begin
                state_next = emit ? sep_pkg::ST_SUM : sep_pkg::ST_IDLE;
            end
            sep_pkg::ST_SUM:
            begin
                state_next = sep_pkg::ST_SQR;
            end
            sep_pkg::ST_SQR:
            begin
                state_next = sep_pkg::ST_MSTART;
            end
            sep_pkg::ST_MSTART:
            begin
                mag_start  = 1'b1;
                state_next = sep_pkg::ST_MAG;
            end
            sep_pkg::ST_MAG:
            begin
                if (!mag_ctl[0].busy)
                begin
                    state_next = sep_pkg::ST_OUT;
                end
            end
            sep_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = sep_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sep_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign red_edge   = red_reg;
    assign green_edge = green_reg;
    assign blue_edge  = blue_reg;
    assign last_pixel = last_out_reg;

    // an accepted item always moves on to the line store update
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == sep_pkg::ST_READ)
        else $error("accepted item did not reach line store update");

    // a new result only appears out of the output load state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == sep_pkg::ST_OUT)
        else $error("result appeared without output load");

    // root units run in lockstep
    a_mag_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        mag_ctl[0].busy == mag_ctl[1].busy && mag_ctl[1].busy == mag_ctl[2].busy)
        else $error("magnitude units out of step");

endmodule
